### design/csh_pkg.sv
`default_nettype none

package csh_pkg;

  // Fixed-point formats of the ports.
  localparam int FB = 14;
  localparam int RB = 16;

  // Shift that takes a uniform fraction to Q.60 before the square root.
  localparam int RAND_SHIFT = 60 - RB;

  // Square root unit: 62-bit radicand, one result bit per stage.
  localparam int SQ_W   = 62;
  localparam int SQ_LAT = SQ_W / 2;

  // Tangent divider: one quotient bit per stage.
  localparam int DIV_QB = 17;

  // Sine and cosine unit: angle stage, square stage, seven terms of three
  // stages each, then the clamp and quadrant stage.
  localparam int SC_LAT = 24;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef logic signed [15:0] coord_t;
  typedef logic [RB-1:0] rand_t;

endpackage

`default_nettype wire

### design/cosine_hemisphere_sample_unit.sv
`default_nettype none

// Channel  | Ports                                     | Direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_stall, in_normal_*, in_rand_* | sink
// result   | out_valid, out_stall, out_dir_*           | source
//
// One transaction enters every cycle unless a held result stalls the pipeline.
// The latency is set by the tangent path: a 31-stage square root followed by
// a 17-stage divider, then the cross product and the final sum.
// Reset clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.

module cosine_hemisphere_sample_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  csh_pkg::coord_t in_normal_x,
  input  csh_pkg::coord_t in_normal_y,
  input  csh_pkg::coord_t in_normal_z,
  input  csh_pkg::rand_t  in_rand_azimuth,
  input  csh_pkg::rand_t  in_rand_elevation,
  output logic            out_valid,
  input  logic            out_stall,
  output csh_pkg::coord_t out_dir_x,
  output csh_pkg::coord_t out_dir_y,
  output csh_pkg::coord_t out_dir_z
);

  import csh_pkg::*;

  // Cycle at which each value is held in a register.
  localparam int T_IN  = 1;
  localparam int T_S   = 3;
  localparam int T_L   = T_S + SQ_LAT;
  localparam int T_Q   = T_L + DIV_QB;
  localparam int T_T1  = T_Q + 1;
  localparam int T_T2  = T_T1 + 2;
  localparam int T_SC  = T_IN + SC_LAT;
  localparam int T_R   = T_IN + SQ_LAT;
  localparam int T_C   = T_R + 2;
  localparam int T_OUT = T_T2 + 2;

  localparam int TW  = 17;
  localparam int NW  = 2 * FB + TW + 3;
  localparam int RTW = SQ_LAT;

  logic                  en;
  logic [T_OUT:1]        vld_r;
  logic [T_OUT:1]        vld_nxt;

  coord_t                n_in [3];
  logic [TW-1:0]         mag [3];
  logic                  sel_y;
  logic                  sel_z;
  logic [TW-1:0]         amin;
  logic signed [TW-1:0]  t1raw_nxt [3];
  logic signed [TW-1:0]  t1raw_r [3];
  coord_t                n_r [3];
  rand_t                 azi_r;
  rand_t                 elev_r;

  logic signed [2*TW-1:0] sqp [3];
  logic [31:0]           sq_r [3];
  logic [31:0]           s_r;

  logic [RTW-1:0]        len;
  logic [3*TW-1:0]       t1raw_d;
  logic [NW-1:0]         num [3];
  logic [3:0]            flg_in;
  logic [3:0]            flg_d;
  logic [DIV_QB-1:0]     quo [3];
  logic signed [17:0]    t1_nxt [3];
  logic signed [17:0]    t1_r [3];

  logic [47:0]           n_t1;
  logic [47:0]           n_t2;
  logic signed [33:0]    pm_r [6];
  logic signed [21:0]    t2_nxt [3];
  logic signed [21:0]    t2_r [3];
  logic [53:0]           t1_dp;

  logic signed [31:0]    cq;
  logic signed [31:0]    sq;
  logic [63:0]           cs_d;
  logic [RTW-1:0]        rz;
  logic [RTW-1:0]        rc;
  logic [RTW-1:0]        rz_d;
  logic signed [63:0]    pcx_r;
  logic signed [63:0]    pcy_r;
  logic signed [31:0]    cx_r;
  logic signed [31:0]    cy_r;
  logic [63:0]           cxy_d;

  logic signed [49:0]    f0_r [3];
  logic signed [53:0]    f1_r [3];
  logic signed [47:0]    f2_r [3];
  logic signed [55:0]    vsum [3];
  logic signed [25:0]    vsh [3];
  coord_t                dir_nxt [3];
  coord_t                dir_r [3];

  // Global advance: the pipeline moves unless a finished result is held.
  assign in_stall = vld_r[T_OUT] & out_stall;
  assign en       = ~in_stall;

  assign vld_nxt = {vld_r[T_OUT-1:1], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Drop the component of smallest magnitude and build the raw tangent.
  assign n_in[0] = in_normal_x;
  assign n_in[1] = in_normal_y;
  assign n_in[2] = in_normal_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = n_in[i][15] ? -TW'(n_in[i]) : TW'(n_in[i]);
    end
    sel_y = mag[1] < mag[0];
    amin  = sel_y ? mag[1] : mag[0];
    sel_z = mag[2] < amin;
    if (sel_z) begin
      t1raw_nxt[0] = -TW'(n_in[1]);
      t1raw_nxt[1] = TW'(n_in[0]);
      t1raw_nxt[2] = '0;
    end else if (sel_y) begin
      t1raw_nxt[0] = -TW'(n_in[2]);
      t1raw_nxt[1] = '0;
      t1raw_nxt[2] = TW'(n_in[0]);
    end else begin
      t1raw_nxt[0] = '0;
      t1raw_nxt[1] = TW'(n_in[2]);
      t1raw_nxt[2] = -TW'(n_in[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1raw_r <= t1raw_nxt;
      n_r     <= n_in;
      azi_r   <= in_rand_azimuth;
      elev_r  <= in_rand_elevation;
    end
  end

  // Squared length of the raw tangent.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp[i] = t1raw_r[i] * t1raw_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sqp[i][31:0];
      end
      s_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  csh_isqrt #(.W(SQ_W)) u_len (
    .clk      (clk),
    .en       (en),
    .radicand (SQ_W'(s_r) << (2 * FB)),
    .root     (len)
  );

  csh_delay #(.W(3 * TW), .D(T_L - T_IN)) u_dly_t1raw (
    .clk  (clk),
    .en   (en),
    .din  ({t1raw_r[2], t1raw_r[1], t1raw_r[0]}),
    .dout (t1raw_d)
  );

  // Rounded quotients: magnitude times 2^2F over the length, half away.
  for (genvar i = 0; i < 3; i++) begin : g_norm
    logic signed [TW-1:0] raw;
    logic [TW-1:0]        raw_mag;

    assign raw     = $signed(t1raw_d[TW*i +: TW]);
    assign raw_mag = raw[TW-1] ? -raw : raw;
    assign num[i]  = (NW'(raw_mag) << (2 * FB)) + NW'(len >> 1);
    assign flg_in[i] = raw[TW-1];

    csh_div #(.NW(NW), .DW(RTW), .QB(DIV_QB)) u_div (
      .clk (clk),
      .en  (en),
      .num (num[i]),
      .den (len),
      .quo (quo[i])
    );
  end

  assign flg_in[3] = (len == '0);

  csh_delay #(.W(4), .D(DIV_QB)) u_dly_flg (
    .clk  (clk),
    .en   (en),
    .din  (flg_in),
    .dout (flg_d)
  );

  // Sign back on; a zero-length tangent stays zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (flg_d[3]) begin
        t1_nxt[i] = '0;
      end else if (flg_d[i]) begin
        t1_nxt[i] = -$signed({1'b0, quo[i]});
      end else begin
        t1_nxt[i] = $signed({1'b0, quo[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t1_nxt;
    end
  end

  csh_delay #(.W(48), .D(T_T1 - T_IN)) u_dly_n1 (
    .clk  (clk),
    .en   (en),
    .din  ({n_r[2], n_r[1], n_r[0]}),
    .dout (n_t1)
  );

  // Second tangent: cross product of the first tangent and the normal.
  always_ff @(posedge clk) begin
    if (en) begin
      pm_r[0] <= t1_r[1] * $signed(n_t1[47:32]);
      pm_r[1] <= t1_r[2] * $signed(n_t1[31:16]);
      pm_r[2] <= t1_r[2] * $signed(n_t1[15:0]);
      pm_r[3] <= t1_r[0] * $signed(n_t1[47:32]);
      pm_r[4] <= t1_r[0] * $signed(n_t1[31:16]);
      pm_r[5] <= t1_r[1] * $signed(n_t1[15:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t2_nxt[i] = 22'((36'(pm_r[2*i]) - 36'(pm_r[2*i+1]) + 36'sd8192) >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r <= t2_nxt;
    end
  end

  csh_delay #(.W(54), .D(T_T2 - T_T1)) u_dly_t1 (
    .clk  (clk),
    .en   (en),
    .din  ({t1_r[2], t1_r[1], t1_r[0]}),
    .dout (t1_dp)
  );

  csh_delay #(.W(48), .D(T_T2 - T_T1)) u_dly_n2 (
    .clk  (clk),
    .en   (en),
    .din  (n_t1),
    .dout (n_t2)
  );

  // Azimuth and elevation coefficients.
  csh_sincos u_sincos (
    .clk     (clk),
    .en      (en),
    .azimuth (azi_r),
    .cos_q   (cq),
    .sin_q   (sq)
  );

  csh_isqrt #(.W(SQ_W)) u_rz (
    .clk      (clk),
    .en       (en),
    .radicand (SQ_W'(elev_r) << RAND_SHIFT),
    .root     (rz)
  );

  csh_isqrt #(.W(SQ_W)) u_rc (
    .clk      (clk),
    .en       (en),
    .radicand (SQ_W'({1'b1, {RB{1'b0}}} - {1'b0, elev_r}) << RAND_SHIFT),
    .root     (rc)
  );

  csh_delay #(.W(64), .D(T_R - T_SC)) u_dly_cs (
    .clk  (clk),
    .en   (en),
    .din  ({sq, cq}),
    .dout (cs_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pcx_r <= $signed(cs_d[31:0]) * $signed({1'b0, rc});
      pcy_r <= $signed(cs_d[63:32]) * $signed({1'b0, rc});
      cx_r  <= 32'((pcx_r + 64'sd536870912) >>> 30);
      cy_r  <= 32'((pcy_r + 64'sd536870912) >>> 30);
    end
  end

  csh_delay #(.W(64), .D(T_T2 - T_C)) u_dly_cxy (
    .clk  (clk),
    .en   (en),
    .din  ({cy_r, cx_r}),
    .dout (cxy_d)
  );

  csh_delay #(.W(RTW), .D(T_T2 - T_R)) u_dly_rz (
    .clk  (clk),
    .en   (en),
    .din  (rz),
    .dout (rz_d)
  );

  // Weighted sum of the frame vectors, rounded and saturated.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f0_r[i] <= $signed(cxy_d[31:0]) * $signed(t1_dp[18*i +: 18]);
        f1_r[i] <= $signed(cxy_d[63:32]) * t2_r[i];
        f2_r[i] <= $signed({1'b0, rz_d}) * $signed(n_t2[16*i +: 16]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsum[i] = 56'(f0_r[i]) + 56'(f1_r[i]) + 56'(f2_r[i]) + 56'sd536870912;
      vsh[i]  = 26'(vsum[i] >>> 30);
      if (vsh[i] > 26'sd32767) begin
        dir_nxt[i] = 16'sh7fff;
      end else if (vsh[i] < -26'sd32768) begin
        dir_nxt[i] = 16'sh8000;
      end else begin
        dir_nxt[i] = 16'(vsh[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r <= dir_nxt;
    end
  end

  assign out_valid = vld_r[T_OUT];
  assign out_dir_x = dir_r[0];
  assign out_dir_y = dir_r[1];
  assign out_dir_z = dir_r[2];

endmodule

`default_nettype wire

### design/csh_delay.sv
`default_nettype none

module csh_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe_r [D];

  // Shift line that moves only when the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign dout = pipe_r[D-1];

endmodule

`default_nettype wire

### design/csh_isqrt.sv
`default_nettype none

module csh_isqrt #(
  parameter int W = 62
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   radicand,
  output logic [W/2-1:0] root
);

  localparam int LAT = W / 2;

  logic [W-1:0] rem_r [LAT];
  logic [W-1:0] res_r [LAT];

  // One result bit per stage, digit by digit from the top.
  for (genvar k = 0; k < LAT; k++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (LAT - 1 - k));
    logic [W-1:0] rem_in;
    logic [W-1:0] res_in;
    logic [W-1:0] trial;
    logic [W-1:0] rem_nxt;
    logic [W-1:0] res_nxt;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[LAT-1][LAT-1:0];

endmodule

`default_nettype wire

### design/csh_div.sv
`default_nettype none

module csh_div #(
  parameter int NW = 48,
  parameter int DW = 31,
  parameter int QB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  localparam int RW = (DW + QB > NW) ? DW + QB : NW;

  logic [RW-1:0] rem_r [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];

  // Restoring division, one quotient bit per stage from the top.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int J = QB - 1 - k;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [RW-1:0] sub;
    logic [RW-1:0] rem_nxt;
    logic [QB-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      sub     = RW'(den_in) << J;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= sub) begin
        rem_nxt    = rem_in - sub;
        quo_nxt[J] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

`default_nettype wire

### design/csh_sincos.sv
`default_nettype none

module csh_sincos (
  input  logic                clk,
  input  logic                en,
  input  csh_pkg::rand_t      azimuth,
  output logic signed [31:0]  cos_q,
  output logic signed [31:0]  sin_q
);

  import csh_pkg::*;

  localparam int STEPS = 7;
  localparam int SLOTS = 3 * STEPS + 1;
  localparam int PW    = RB + 31;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [31:0]        t_s;
    logic [31:0]        t_c;
    logic signed [33:0] acc_s;
    logic signed [33:0] acc_c;
    logic [31:0]        x2;
    quad_t              quad;
    logic [31:0]        x_s;
    logic [31:0]        x_c;
    logic [31:0]        q0_s;
    logic [31:0]        q0_c;
  } sc_slot_t;

  logic [PW-1:0]      theta_p;
  logic [30:0]        theta_r;
  quad_t              quad_r;
  logic [61:0]        theta_sq;
  sc_slot_t           slot_nxt0;
  sc_slot_t           slot_r [SLOTS];
  logic signed [33:0] c_cl;
  logic signed [33:0] s_cl;
  logic signed [31:0] cos_nxt;
  logic signed [31:0] sin_nxt;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  // Angle of the low bits within the quadrant, in Q.30.
  assign theta_p = PW'(azimuth[RB-3:0]) * PW'(TWO_PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= 31'(theta_p >> RB);
      quad_r  <= quad_t'(azimuth[RB-1 -: 2]);
    end
  end

  // Square of the angle and the first term of each series.
  assign theta_sq = 62'(theta_r) * 62'(theta_r);

  always_comb begin
    slot_nxt0       = '0;
    slot_nxt0.t_s   = 32'(theta_r);
    slot_nxt0.acc_s = 34'(theta_r);
    slot_nxt0.t_c   = 32'(ONE_Q30);
    slot_nxt0.acc_c = ONE_Q30;
    slot_nxt0.x2    = 32'(theta_sq >> 30);
    slot_nxt0.quad  = quad_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_r[0] <= slot_nxt0;
    end
  end

  // Each term takes three stages: product with the squared angle, reciprocal
  // product, then the quotient correction and the accumulation.
  for (genvar j = 1; j < SLOTS; j++) begin : g_slot
    localparam int K   = (j - 1) / 3 + 1;
    localparam int SUB = (j - 1) % 3;
    localparam int DS  = (2 * K) * (2 * K + 1);
    localparam int DC  = (2 * K - 1) * (2 * K);
    localparam logic [31:0] RS = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] RC = 32'((64'd1 << 32) / DC);
    sc_slot_t    cur;
    sc_slot_t    nxt;
    logic [63:0] prod_s;
    logic [63:0] prod_c;
    logic [39:0] rem_s;
    logic [39:0] rem_c;
    logic [31:0] q_s;
    logic [31:0] q_c;

    assign cur = slot_r[j-1];

    always_comb begin
      nxt    = cur;
      prod_s = '0;
      prod_c = '0;
      rem_s  = '0;
      rem_c  = '0;
      q_s    = '0;
      q_c    = '0;
      case (SUB)
        0: begin
          prod_c  = 64'(cur.t_c) * 64'(cur.x2);
          nxt.x_c = 32'(prod_c >> 30);
          if (K < STEPS) begin
            prod_s  = 64'(cur.t_s) * 64'(cur.x2);
            nxt.x_s = 32'(prod_s >> 30);
          end
        end
        1: begin
          prod_c   = 64'(cur.x_c) * 64'(RC);
          nxt.q0_c = 32'(prod_c >> 32);
          if (K < STEPS) begin
            prod_s   = 64'(cur.x_s) * 64'(RS);
            nxt.q0_s = 32'(prod_s >> 32);
          end
        end
        default: begin
          rem_c   = 40'(cur.x_c) - 40'(cur.q0_c) * 40'(DC);
          q_c     = (rem_c >= 40'(DC)) ? cur.q0_c + 32'd1 : cur.q0_c;
          nxt.t_c = q_c;
          if (K % 2 == 1) begin
            nxt.acc_c = cur.acc_c - $signed({2'b00, q_c});
          end else begin
            nxt.acc_c = cur.acc_c + $signed({2'b00, q_c});
          end
          if (K < STEPS) begin
            rem_s   = 40'(cur.x_s) - 40'(cur.q0_s) * 40'(DS);
            q_s     = (rem_s >= 40'(DS)) ? cur.q0_s + 32'd1 : cur.q0_s;
            nxt.t_s = q_s;
            if (K % 2 == 1) begin
              nxt.acc_s = cur.acc_s - $signed({2'b00, q_s});
            end else begin
              nxt.acc_s = cur.acc_s + $signed({2'b00, q_s});
            end
          end
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        slot_r[j] <= nxt;
      end
    end
  end

  // Clamp both sums to the unit range, then rotate into the quadrant.
  always_comb begin
    c_cl = slot_r[SLOTS-1].acc_c;
    s_cl = slot_r[SLOTS-1].acc_s;
    if (c_cl < 0) begin
      c_cl = '0;
    end else if (c_cl > ONE_Q30) begin
      c_cl = ONE_Q30;
    end
    if (s_cl < 0) begin
      s_cl = '0;
    end else if (s_cl > ONE_Q30) begin
      s_cl = ONE_Q30;
    end
    case (slot_r[SLOTS-1].quad)
      QUAD_0: begin
        cos_nxt = 32'(c_cl);
        sin_nxt = 32'(s_cl);
      end
      QUAD_1: begin
        cos_nxt = -32'(s_cl);
        sin_nxt = 32'(c_cl);
      end
      QUAD_2: begin
        cos_nxt = -32'(c_cl);
        sin_nxt = -32'(s_cl);
      end
      QUAD_3: begin
        cos_nxt = 32'(s_cl);
        sin_nxt = -32'(c_cl);
      end
      default: begin
        cos_nxt = 32'(c_cl);
        sin_nxt = 32'(s_cl);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

`default_nettype wire

### design/csh_checker.sv
`default_nettype none

module csh_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire signed [15:0] out_dir_x,
  input wire signed [15:0] out_dir_y,
  input wire signed [15:0] out_dir_z
);

  // The input side is held back only while a result waits at the output.
  a_stall_cause : assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a held result");

  // No result is shown in the cycle after reset.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A held result keeps its payload.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dir_x)
      && $stable(out_dir_y) && $stable(out_dir_z))
    else $error("held result changed");

  // The input is never stalled while no result is pending at the output.
  a_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("stall with no result pending");

endmodule

bind cosine_hemisphere_sample_unit csh_checker u_csh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_dir_x (out_dir_x),
  .out_dir_y (out_dir_y),
  .out_dir_z (out_dir_z)
);

`default_nettype wire

### test/cosine_hemisphere_sample_unit_tb.sv
`timescale 1ns / 1ps

// Expected directions, predicted from each normal and pair of fractions.
class direction_scoreboard;
  logic signed [15:0] pend_x[$];
  logic signed [15:0] pend_y[$];
  logic signed [15:0] pend_z[$];
  int errors = 0;

  // Floor shift of a signed value.
  static function longint asr_floor(longint v, int sh);
    return v >>> sh;
  endfunction

  static function longint asr_round(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  static function longint quot_round(longint n, longint d);
    longint m;
    longint q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  static function longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > (longint'(1) << 30)) return longint'(1) << 30;
    return v;
  endfunction

  // Taylor series sine and cosine in Q.30 for an angle in the first quadrant.
  static function void sin_cos(longint unsigned ang, output longint sv, output longint cv);
    longint unsigned sq;
    longint unsigned term;
    longint acc;
    sq = (ang * ang) >> 30;
    term = ang;
    acc = longint'(ang);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    sv = unit_clamp(acc);
    term = longint'(1) << 30;
    acc = longint'(1) << 30;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * sq) >> 30) / longint'((2 * k - 1) * (2 * k));
      acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    cv = unit_clamp(acc);
  endfunction

  // Note the expected direction of one accepted input transaction.
  function void note_input(logic signed [15:0] nx, logic signed [15:0] ny,
                           logic signed [15:0] nz, logic [15:0] az, logic [15:0] el);
    longint n[3];
    longint mag[3];
    longint t1[3];
    longint t2[3];
    longint v[3];
    longint sv, cv, cq, sq, cx, cy;
    longint unsigned len, rz, rc, ang;
    int drop;
    n[0] = nx;
    n[1] = ny;
    n[2] = nz;
    for (int i = 0; i < 3; i++) mag[i] = (n[i] < 0) ? -n[i] : n[i];
    drop = 0;
    if (mag[1] < mag[drop]) drop = 1;
    if (mag[2] < mag[drop]) drop = 2;
    case (drop)
      0: begin t1[0] = 0; t1[1] = n[2]; t1[2] = -n[1]; end
      1: begin t1[0] = -n[2]; t1[1] = 0; t1[2] = n[0]; end
      default: begin t1[0] = -n[1]; t1[1] = n[0]; t1[2] = 0; end
    endcase
    len = root_floor(longint'(t1[0] * t1[0] + t1[1] * t1[1] + t1[2] * t1[2]) << 28);
    if (len != 0)
      for (int i = 0; i < 3; i++) t1[i] = quot_round(t1[i] <<< 28, longint'(len));
    t2[0] = asr_round(t1[1] * n[2] - t1[2] * n[1], 14);
    t2[1] = asr_round(t1[2] * n[0] - t1[0] * n[2], 14);
    t2[2] = asr_round(t1[0] * n[1] - t1[1] * n[0], 14);
    ang = (longint'(az[13:0]) * 64'd6746518852) >> 16;
    sin_cos(ang, sv, cv);
    case (az[15:14])
      2'd0: begin cq = cv; sq = sv; end
      2'd1: begin cq = -sv; sq = cv; end
      2'd2: begin cq = -cv; sq = -sv; end
      default: begin cq = sv; sq = -cv; end
    endcase
    rz = root_floor(longint'(el) << 44);
    rc = root_floor((longint'(65536) - longint'(el)) << 44);
    cx = asr_round(cq * longint'(rc), 30);
    cy = asr_round(sq * longint'(rc), 30);
    for (int i = 0; i < 3; i++) begin
      v[i] = asr_round(cx * t1[i] + cy * t2[i] + longint'(rz) * n[i], 30);
      if (v[i] > 32767) v[i] = 32767;
      if (v[i] < -32768) v[i] = -32768;
    end
    pend_x.push_back(v[0][15:0]);
    pend_y.push_back(v[1][15:0]);
    pend_z.push_back(v[2][15:0]);
  endfunction

  // Compare one accepted result transaction with the oldest expectation.
  function void check_result(logic signed [15:0] dx, logic signed [15:0] dy,
                             logic signed [15:0] dz);
    logic signed [15:0] ex, ey, ez;
    if (pend_x.size() == 0) begin
      $display("%0t: unexpected result %0d %0d %0d", $time, dx, dy, dz);
      errors++;
      return;
    end
    ex = pend_x.pop_front();
    ey = pend_y.pop_front();
    ez = pend_z.pop_front();
    if (dx !== ex) begin
      $display("%0t: dir_x expected %0d actual %0d", $time, ex, dx);
      errors++;
    end
    if (dy !== ey) begin
      $display("%0t: dir_y expected %0d actual %0d", $time, ey, dy);
      errors++;
    end
    if (dz !== ez) begin
      $display("%0t: dir_z expected %0d actual %0d", $time, ez, dz);
      errors++;
    end
  endfunction
endclass

module cosine_hemisphere_sample_unit_tb;
  import csh_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t in_normal_x, in_normal_y, in_normal_z;
  rand_t in_rand_azimuth, in_rand_elevation;
  logic out_valid;
  logic out_stall;
  coord_t out_dir_x, out_dir_y, out_dir_z;

  direction_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  int quiet_cycles;

  cosine_hemisphere_sample_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .in_rand_azimuth(in_rand_azimuth), .in_rand_elevation(in_rand_elevation),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_input(in_normal_x, in_normal_y, in_normal_z,
                         in_rand_azimuth, in_rand_elevation);
      if (out_valid && !out_stall)
        board.check_result(out_dir_x, out_dir_y, out_dir_z);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on cycles with no transaction.
  always @(posedge clk) begin
    if (quiet_cycles > 3000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stall, driven at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one transaction and wait for it to be taken.
  task automatic send_item(coord_t nx, coord_t ny, coord_t nz, rand_t az, rand_t el);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_normal_x <= nx;
    in_normal_y <= ny;
    in_normal_z <= nz;
    in_rand_azimuth <= az;
    in_rand_elevation <= el;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly unit-like normals, with some of the full input range.
  function automatic coord_t pick_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(32)) - 16;
      default: return coord_t'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++)
      send_item(pick_coord(), pick_coord(), pick_coord(), rand_t'($urandom), rand_t'($urandom));
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_normal_x = '0;
    in_normal_y = '0;
    in_normal_z = '0;
    in_rand_azimuth = '0;
    in_rand_elevation = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b0;
    quiet_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: axes, ties, zero tangent, extremes, quadrants, elevation ends.
    send_item(16384, 0, 0, 0, 0);
    send_item(0, 16384, 0, 16384, 65535);
    send_item(0, 0, -16384, 32768, 32768);
    send_item(9459, 9459, 9459, 49152, 1);
    send_item(-9459, 9459, -9459, 65535, 40000);
    send_item(0, 0, 0, 1234, 5000);
    send_item(0, 0, 5000, 8192, 0);
    send_item(-32768, -32768, -32768, 65535, 65535);
    send_item(32767, 32767, 32767, 0, 65535);
    send_item(-32768, 32767, 0, 16383, 100);
    send_item(32767, -32768, 1, 16384, 0);
    send_item(0, 0, 16384, 12345, 65535);
    send_item(11585, -11585, 0, 40000, 20000);
    send_item(100, 200, 16000, 65534, 32767);
    send_item(-16384, 0, 0, 49151, 0);

    // Long receiver hold-off so the pipeline fills and stalls its input.
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end
      random_items(100);
    join

    send_idle_pct = 37;
    recv_idle_pct = 79;
    random_items(200);
    send_idle_pct = 79;
    recv_idle_pct = 37;
    random_items(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(200);
    in_valid <= 1'b0;

    while (board.pend_x.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
